FILE: src/kdrc_pkg.sv
`timescale 1ns / 1ps

package kdrc_pkg;

  localparam int LAYERS     = 10;
  localparam int COORD_BITS = 24;

  localparam int IDX_W      = LAYERS + 1;
  localparam int TABLE_SIZE = 1 << IDX_W;
  localparam int LEVEL_SIZE = 1 << LAYERS;
  localparam int FQ_PTR_W   = LAYERS;
  localparam int FQ_CNT_W   = LAYERS + 1;

  localparam int OP_W    = 2;
  localparam int NIDX_W  = 11;
  localparam int PT_W    = 24;
  localparam int RAD_W   = 26;
  localparam int BELOW_W = 11;
  localparam int CNT_W   = 11;
  localparam int TOTAL_W = 40;

  localparam int DIFF_W = COORD_BITS;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [IDX_W-1:0]   idx;
    logic [PT_W-1:0]    px;
    logic [PT_W-1:0]    py;
    logic [PT_W-1:0]    pz;
    logic [RAD_W-1:0]   ext;
    logic [BELOW_W-1:0] below;
  } cmd_t;

  typedef struct packed {
    logic [PT_W-1:0]    cx;
    logic [PT_W-1:0]    cy;
    logic [PT_W-1:0]    cz;
    logic [RAD_W-1:0]   ext;
    logic [BELOW_W-1:0] below;
  } node_t;

endpackage

FILE: src/kdrc_in_if.sv
`timescale 1ns / 1ps

interface kdrc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [10:0] node_index;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic signed [23:0] point_z;
  logic [25:0] node_extent;
  logic [10:0] point_total;

  modport source (output valid, operation, node_index, point_x, point_y, point_z,
                  node_extent, point_total, input ready);
  modport sink (input valid, operation, node_index, point_x, point_y, point_z,
                node_extent, point_total, output ready);
endinterface

FILE: src/kdrc_out_if.sv
`timescale 1ns / 1ps

interface kdrc_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] query_count;
  logic [39:0] running_total;

  modport source (output valid, query_count, running_total, input ready);
  modport sink (input valid, query_count, running_total, output ready);
endinterface

FILE: src/kdrc_front.sv
`timescale 1ns / 1ps

module kdrc_front (
  input  logic          clk,
  input  logic          rst_n,
  kdrc_in_if.sink       in_ch,
  output kdrc_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);

  kdrc_pkg::cmd_t q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       take;
  logic       keep;
  logic       push;
  logic       pop;
  kdrc_pkg::cmd_t incoming;

  // drop unused opcode and writes to node index zero
  always_comb begin
    keep = 1'b0;
    case (in_ch.operation)
      kdrc_pkg::OP_WRITE: keep = (in_ch.node_index != '0) &&
                                 ({1'b0, in_ch.node_index} < 12'(kdrc_pkg::TABLE_SIZE));
      kdrc_pkg::OP_QUERY: keep = 1'b1;
      kdrc_pkg::OP_CLEAR: keep = 1'b1;
      default:            keep = 1'b0;
    endcase
  end

  always_comb begin
    incoming.op    = in_ch.operation;
    incoming.idx   = in_ch.node_index[kdrc_pkg::IDX_W-1:0];
    incoming.px    = in_ch.point_x;
    incoming.py    = in_ch.point_y;
    incoming.pz    = in_ch.point_z;
    incoming.ext   = in_ch.node_extent;
    incoming.below = in_ch.point_total;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign take        = in_ch.valid && in_ch.ready;
  assign push        = take && keep;
  assign pop         = cmd_pop && cmd_valid;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= incoming;
    end
  end

endmodule

FILE: src/kdrc_isqrt.sv
`timescale 1ns / 1ps

module kdrc_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [kdrc_pkg::SUM_W-1:0]   radicand,
  output logic                         busy,
  output logic                         done,
  output logic [kdrc_pkg::ROOT_W-1:0]  root
);

  localparam int RW  = kdrc_pkg::ROOT_W;
  localparam int SW  = kdrc_pkg::SUM_W;
  localparam int CW  = $clog2(RW + 1);

  logic [SW-1:0] rad_r;
  logic [RW:0]   rem_r;
  logic [RW-1:0] root_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [RW+2:0] rem_t;
  logic [RW+2:0] trial;
  logic          fits;

  // one result bit a cycle, restoring method
  always_comb begin
    rem_t = {rem_r, rad_r[SW-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
    fits  = (rem_t >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[SW-3:0], 2'b00};
      if (fits) begin
        // remainder stays below 2*root+1, so the low bits hold it exactly
        rem_r  <= rem_t[RW:0] - trial[RW:0];
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_t[RW:0];
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

FILE: src/kdrc_back.sv
`timescale 1ns / 1ps

module kdrc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kdrc_pkg::cmd_t              cmd,
  input  logic                        cmd_valid,
  output logic                        cmd_pop,
  input  logic [kdrc_pkg::RAD_W-1:0]  radius,
  kdrc_out_if.source                  out_ch
);

  localparam int IW = kdrc_pkg::IDX_W;
  localparam int CB = kdrc_pkg::COORD_BITS;
  localparam int DW = kdrc_pkg::DIFF_W;
  localparam int QW = kdrc_pkg::SQ_W;
  localparam int SW = kdrc_pkg::SUM_W;
  localparam int RW = kdrc_pkg::ROOT_W;
  localparam int AW = kdrc_pkg::RAD_W;
  localparam int PW = kdrc_pkg::FQ_PTR_W;
  localparam int NW = kdrc_pkg::FQ_CNT_W;
  localparam int KW = kdrc_pkg::CNT_W;
  localparam int TW = kdrc_pkg::TOTAL_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_POP    = 4'd1;
  localparam logic [3:0] ST_NODE   = 4'd2;
  localparam logic [3:0] ST_DIFF   = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_SUM    = 4'd5;
  localparam logic [3:0] ST_SQST   = 4'd6;
  localparam logic [3:0] ST_ROOT   = 4'd7;
  localparam logic [3:0] ST_DECIDE = 4'd8;
  localparam logic [3:0] ST_PUSH2  = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  kdrc_pkg::node_t nmem [kdrc_pkg::TABLE_SIZE];
  logic [IW-1:0]   fmem [kdrc_pkg::LEVEL_SIZE];

  logic [3:0]     state_r, state_nxt;
  logic [PW-1:0]  fq_wptr_r, fq_rptr_r;
  logic [NW-1:0]  fq_cnt_r;
  logic           fq_push, fq_pop;
  logic [IW-1:0]  fq_wdata;
  logic [IW-1:0]  fq_rdata_r;
  logic [IW-1:0]  cur_idx_r;
  kdrc_pkg::node_t node_r;

  logic [kdrc_pkg::PT_W-1:0] px_r, py_r, pz_r;
  logic [DW-1:0]  dx_r, dy_r, dz_r;
  logic [QW-1:0]  sx_r, sy_r, sz_r;
  logic [SW-1:0]  sum_r;
  logic [KW-1:0]  count_r;
  logic [TW-1:0]  total_r;

  logic           out_valid_r;
  logic [KW-1:0]  out_count_r;
  logic [TW-1:0]  out_total_r;

  logic           sq_start, sq_busy, sq_done;
  logic [RW-1:0]  root_dist;
  logic [AW:0]    dist_ext, rad_ext;
  logic           whole, descend, has_kids;
  logic [KW:0]    count_sum;
  logic [TW:0]    total_sum;

  function automatic logic [DW-1:0] abs_diff(input logic [kdrc_pkg::PT_W-1:0] a,
                                             input logic [kdrc_pkg::PT_W-1:0] b);
    logic [CB:0] d;
    d = {a[CB-1], a[CB-1:0]} - {b[CB-1], b[CB-1:0]};
    if (d[CB]) begin
      d = -d;
    end
    return d[DW-1:0];
  endfunction

  kdrc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_r),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (root_dist)
  );

  assign sq_start = (state_r == ST_SQST);

  always_comb begin
    dist_ext  = (AW+1)'(root_dist) + {1'b0, node_r.ext};
    rad_ext   = {1'b0, radius} + {1'b0, node_r.ext};
    whole     = ({1'b0, radius} >= dist_ext);
    descend   = ((AW+1)'(root_dist) <= rad_ext);
    has_kids  = !cur_idx_r[IW-1];
    count_sum = {1'b0, count_r} + {1'b0, node_r.below};
    total_sum = {1'b0, total_r} + (TW+1)'(count_r);
  end

  // frontier queue control
  always_comb begin
    fq_push  = 1'b0;
    fq_wdata = IW'(1);
    fq_pop   = (state_r == ST_POP) && (fq_cnt_r != '0);
    case (state_r)
      ST_IDLE: begin
        fq_push  = cmd_valid && (cmd.op == kdrc_pkg::OP_QUERY);
        fq_wdata = IW'(1);
      end
      ST_DECIDE: begin
        fq_push  = !whole && descend && has_kids;
        fq_wdata = {cur_idx_r[IW-2:0], 1'b0};
      end
      ST_PUSH2: begin
        fq_push  = 1'b1;
        fq_wdata = {cur_idx_r[IW-2:0], 1'b1};
      end
      default: begin
        fq_push = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == kdrc_pkg::OP_QUERY) begin
            state_nxt = ST_POP;
          end
        end
      end
      ST_POP:    state_nxt = (fq_cnt_r == '0) ? ST_DONE : ST_NODE;
      ST_NODE:   state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_SQST;
      ST_SQST:   state_nxt = ST_ROOT;
      ST_ROOT:   state_nxt = sq_done ? ST_DECIDE : ST_ROOT;
      ST_DECIDE: state_nxt = (!whole && descend && has_kids) ? ST_PUSH2 : ST_POP;
      ST_PUSH2:  state_nxt = ST_POP;
      ST_DONE:   state_nxt = (!out_valid_r || out_ch.ready) ? ST_IDLE : ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fq_wptr_r   <= '0;
      fq_rptr_r   <= '0;
      fq_cnt_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fq_push) begin
        fq_wptr_r <= fq_wptr_r + 1'b1;
      end
      if (fq_pop) begin
        fq_rptr_r <= fq_rptr_r + 1'b1;
      end
      fq_cnt_r <= fq_cnt_r + NW'(fq_push) - NW'(fq_pop);
      if (state_r == ST_IDLE && cmd_valid && cmd.op == kdrc_pkg::OP_CLEAR) begin
        total_r <= '0;
      end
      if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        // saturate the running total at its top value
        total_r     <= total_sum[TW] ? '1 : total_sum[TW-1:0];
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cmd_valid && cmd.op == kdrc_pkg::OP_QUERY) begin
      px_r    <= cmd.px;
      py_r    <= cmd.py;
      pz_r    <= cmd.pz;
      count_r <= '0;
    end
    if (state_r == ST_NODE) begin
      cur_idx_r <= fq_rdata_r;
    end
    if (state_r == ST_DIFF) begin
      dx_r <= abs_diff(px_r, node_r.cx);
      dy_r <= abs_diff(py_r, node_r.cy);
      dz_r <= abs_diff(pz_r, node_r.cz);
    end
    if (state_r == ST_MUL) begin
      sx_r <= dx_r * dx_r;
      sy_r <= dy_r * dy_r;
      sz_r <= dz_r * dz_r;
    end
    if (state_r == ST_SUM) begin
      sum_r <= SW'(sx_r) + SW'(sy_r) + SW'(sz_r);
    end
    if (state_r == ST_DECIDE && whole) begin
      count_r <= count_sum[KW] ? '1 : count_sum[KW-1:0];
    end
    if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
      out_count_r <= count_r;
      out_total_r <= total_sum[TW] ? '1 : total_sum[TW-1:0];
    end
  end

  // node table
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cmd_valid && cmd.op == kdrc_pkg::OP_WRITE) begin
      nmem[cmd.idx] <= '{cx: cmd.px, cy: cmd.py, cz: cmd.pz, ext: cmd.ext,
                         below: cmd.below};
    end
    if (state_r == ST_NODE) begin
      node_r <= nmem[fq_rdata_r];
    end
  end

  // frontier queue storage
  always_ff @(posedge clk) begin
    if (fq_push) begin
      fmem[fq_wptr_r] <= fq_wdata;
    end
    if (fq_pop) begin
      fq_rdata_r <= fmem[fq_rptr_r];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.query_count   = out_count_r;
  assign out_ch.running_total = out_total_r;

`ifndef NO_ASSERTIONS
  a_fq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fq_cnt_r <= NW'(kdrc_pkg::LEVEL_SIZE))
    else $error("frontier queue overfilled");

  a_sq_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_busy)
    else $error("square root started while busy");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside done state");

  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(fq_push && fq_pop))
    else $error("frontier push and pop in one cycle");
`endif

endmodule

FILE: src/kd_tree_radius_count_top.sv
`timescale 1ns / 1ps

// fixed-radius neighbor count over an implicit heap-indexed 3-d tree
// in_ch: valid/ready channel; operation selects node write, radius query
//   or clear of the running total; one item per beat
// out_ch: valid/ready channel; one beat per query with query_count and
//   the saturating running_total after that query
// cfg_we/cfg_wdata: writes search_radius; change it only while idle
// the front takes items into a two-entry command queue, dropping unused
//   opcodes and writes to node index zero; the back executes them in order
// the back retires a write or clear straight from its idle state
// a query visits nodes one at a time, each through frontier read, table
//   read, difference, squares, sum, square root with start and done,
//   decision and, when both children are queued, a second child push; a
//   full walk covers up to 2047 nodes, and the square root unit is the
//   longest step of each visit
// the front keeps accepting while the back is busy until its queue fills
// when the receiver stalls, the finished result waits in the output
//   register and the back holds in its done state
// reset (synchronous, active low) clears the total, radius and queues;
//   the node table holds nothing until written
module kd_tree_radius_count_top (
  input  logic        clk,
  input  logic        rst_n,
  kdrc_in_if.sink     in_ch,
  kdrc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [25:0] cfg_wdata
);

  logic [kdrc_pkg::RAD_W-1:0] radius_r;
  kdrc_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  // search radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // front: accept and classify
  kdrc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // back: node table, tree walk, totals
  kdrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .radius    (radius_r),
    .out_ch    (out_ch)
  );

endmodule

FILE: sim/kdrc_checker.sv
`timescale 1ns / 1ps

module kdrc_checker
  import kdrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  kdrc_in_if                in_mon,
  kdrc_out_if               out_mon,
  input  logic              cfg_we,
  input  logic [RAD_W-1:0]  cfg_wdata,
  output int                fails,
  output int                pending
);

  localparam logic [CNT_W-1:0]   CNT_SAT   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

  typedef struct {
    logic signed [PT_W-1:0] cx;
    logic signed [PT_W-1:0] cy;
    logic signed [PT_W-1:0] cz;
    logic [RAD_W-1:0]       ext;
    logic [BELOW_W-1:0]     below;
  } tree_node_t;

  typedef struct {
    logic [CNT_W-1:0]   cnt;
    logic [TOTAL_W-1:0] total;
  } tally_t;

  tree_node_t       node_tab [TABLE_SIZE];
  logic [RAD_W-1:0]   radius;
  logic [TOTAL_W-1:0] total_sum;
  tally_t           tally_q [$];

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned sq_gap(longint a, longint b);
    longint unsigned g;
    g = (a >= b) ? longint'(a - b) : longint'(b - a);
    return g * g;
  endfunction

  // level-by-level walk; visiting order does not change the count
  function automatic longint unsigned count_in_radius(logic signed [PT_W-1:0] x,
                                                      logic signed [PT_W-1:0] y,
                                                      logic signed [PT_W-1:0] z);
    int unsigned     walk [$];
    int unsigned     n;
    longint unsigned d;
    longint unsigned e;
    longint unsigned r;
    longint unsigned cnt;
    cnt = 0;
    r   = radius;
    walk.push_back(1);
    while (walk.size() != 0) begin
      n = walk.pop_front();
      d = floor_root(sq_gap(x, node_tab[n].cx) + sq_gap(y, node_tab[n].cy)
                     + sq_gap(z, node_tab[n].cz));
      e = node_tab[n].ext;
      if (r >= d + e) begin
        cnt += node_tab[n].below;
      end else if (d <= r + e) begin
        if (2 * n < TABLE_SIZE) walk.push_back(2 * n);
        if (2 * n + 1 < TABLE_SIZE) walk.push_back(2 * n + 1);
      end
    end
    return cnt;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    longint unsigned c;
    tally_t          t;
    if (!rst_n) begin
      radius    <= '0;
      total_sum = '0;
      tally_q.delete();
    end else begin
      if (cfg_we) radius <= cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.operation)
          OP_WRITE: begin
            if (in_mon.node_index != 0) begin
              node_tab[in_mon.node_index] = '{in_mon.point_x, in_mon.point_y,
                in_mon.point_z, in_mon.node_extent, in_mon.point_total};
            end
          end
          OP_QUERY: begin
            c = count_in_radius(in_mon.point_x, in_mon.point_y, in_mon.point_z);
            if (c > CNT_SAT) c = CNT_SAT;
            if (total_sum > TOTAL_SAT - c) total_sum = TOTAL_SAT;
            else total_sum = total_sum + c;
            tally_q.push_back('{c[CNT_W-1:0], total_sum});
          end
          OP_CLEAR: total_sum = '0;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (tally_q.size() == 0) begin
          // a result beat with no query waiting for it
          report("result beat with no query", out_mon.query_count, 0);
        end else begin
          t = tally_q.pop_front();
          if (out_mon.query_count !== t.cnt)
            report("query_count", out_mon.query_count, t.cnt);
          if (out_mon.running_total !== t.total)
            report("running_total", out_mon.running_total, t.total);
        end
      end
    end
    pending = tally_q.size();
  end

endmodule

FILE: sim/kd_tree_radius_count_top_tb.sv
`timescale 1ns / 1ps

module kd_tree_radius_count_top_tb;
  import kdrc_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int COORD_MAX = 8388607;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [RAD_W-1:0] cfg_wdata;

  kdrc_in_if  in_ch ();
  kdrc_out_if out_ch ();

  int fails;
  int pending;

  // stimulus controls shared with the receiver process
  bit quiet;
  bit hold_req;

  // tree shape currently loaded; only these nodes can be reached by a query
  int unsigned shape_nodes [$];
  bit          inner_node [TABLE_SIZE];

  int n_writes, n_queries, n_clears, n_noise, idle_cnt;

  kd_tree_radius_count_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  kdrc_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .fails    (fails),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stall bursts, one long hold on request, none when quiet
  initial begin
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        // long hold counted here so the sender keeps pushing into a full block
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one input beat, with an optional random gap in front of it
  task automatic issue(logic [OP_W-1:0] op, logic [NIDX_W-1:0] idx,
                       logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
                       logic signed [PT_W-1:0] z, logic [RAD_W-1:0] ext,
                       logic [BELOW_W-1:0] below);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.node_index  <= idx;
    in_ch.point_x     <= x;
    in_ch.point_y     <= y;
    in_ch.point_z     <= z;
    in_ch.node_extent <= ext;
    in_ch.point_total <= below;
    do @(posedge clk); while (!in_ch.ready);
    case (op)
      OP_WRITE: n_writes++;
      OP_QUERY: n_queries++;
      OP_CLEAR: n_clears++;
      default:  n_noise++;
    endcase
  endtask

  // drain: every result back, then room for queued writes/clears to retire
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_radius(logic [RAD_W-1:0] r);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // a coordinate near base, or anywhere when wide is set
  function automatic logic signed [PT_W-1:0] near(int base, int spread, bit wide);
    if (wide) return PT_W'($urandom());
    return PT_W'(base + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // leaves above the last level get extent zero so no unloaded child is visited;
  // nodes on the last level may have any extent, their children fall off the table
  task automatic load_node(int unsigned n, int base, int spread, bit wide);
    logic [RAD_W-1:0] e;
    if (inner_node[n])
      e = wide ? RAD_W'($urandom()) : RAD_W'($urandom_range(0, 3 * spread));
    else if (n >= LEVEL_SIZE)
      e = RAD_W'($urandom());
    else
      e = '0;
    issue(OP_WRITE, NIDX_W'(n), near(base, spread, wide), near(base, spread, wide),
          near(base, spread, wide), e, BELOW_W'($urandom_range(0, 2047)));
  endtask

  task automatic add_shape(int unsigned n, bit inner);
    shape_nodes.push_back(n);
    inner_node[n] = inner;
  endtask

  // complete tree of the given depth, or a left spine down to the last level
  task automatic build_tree(int depth, bit spine, int base, int spread, bit wide);
    int unsigned n;
    shape_nodes.delete();
    if (spine) begin
      n = 1;
      while (n < LEVEL_SIZE) begin
        add_shape(n, 1'b1);
        add_shape(2 * n + 1, 1'b0);
        n = 2 * n;
      end
      add_shape(n, 1'b0);
    end else begin
      for (n = 1; n < (1 << depth); n++) add_shape(n, n < (1 << (depth - 1)));
    end
    foreach (shape_nodes[i]) load_node(shape_nodes[i], base, spread, wide);
  endtask

  // mostly queries around the tree, with overwrites, clears and ignored items
  task automatic mixed_run(int items, int base, int spread, bit wide);
    int pick;
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        issue(OP_QUERY, NIDX_W'($urandom()), near(base, spread, wide),
              near(base, spread, wide), near(base, spread, wide), RAD_W'($urandom()),
              BELOW_W'($urandom()));
      else if (pick < 85)
        load_node(shape_nodes[$urandom_range(0, shape_nodes.size() - 1)],
                  base, spread, wide);
      else if (pick < 92)
        issue(OP_CLEAR, NIDX_W'($urandom()), PT_W'($urandom()), PT_W'($urandom()),
              PT_W'($urandom()), RAD_W'($urandom()), BELOW_W'($urandom()));
      else if (pick < 96)
        issue(2'd3, NIDX_W'($urandom()), PT_W'($urandom()), PT_W'($urandom()),
              PT_W'($urandom()), RAD_W'($urandom()), BELOW_W'($urandom()));
      else
        // a write to node index zero must be dropped
        issue(OP_WRITE, '0, PT_W'($urandom()), PT_W'($urandom()), PT_W'($urandom()),
              RAD_W'($urandom()), BELOW_W'($urandom()));
    end
  endtask

  initial begin
    int base;
    int spread;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_WRITE;
    in_ch.node_index  <= '0;
    in_ch.point_x     <= '0;
    in_ch.point_y     <= '0;
    in_ch.point_z     <= '0;
    in_ch.node_extent <= '0;
    in_ch.point_total <= '0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: a three-level tree with corner centers and a max-extent root
    set_radius(26'd1000);
    issue(OP_WRITE, 11'd1, '0, '0, '0, '1, 11'd7);
    issue(OP_WRITE, 11'd2, -24'sd5000, 24'sd0, 24'sd0, '0, 11'd2047);
    issue(OP_WRITE, 11'd3, 24'sd5000, 24'sd0, 24'sd0, '0, 11'd1024);
    issue(OP_WRITE, 11'd4, -24'sd8388608, -24'sd8388608, -24'sd8388608, '0, 11'd1);
    issue(OP_WRITE, 11'd5, 24'sd8388607, 24'sd8388607, 24'sd8388607, '0, 11'd2047);
    issue(OP_WRITE, 11'd6, 24'sd100, -24'sd100, 24'sd100, '0, 11'd0);
    issue(OP_WRITE, 11'd7, 24'sd200, 24'sd200, -24'sd200, '0, 11'd1024);
    // top of the table is a legal index; index zero is dropped
    issue(OP_WRITE, 11'd2047, '1, '1, '1, '1, '1);
    issue(OP_WRITE, 11'd0, '0, '0, '0, '1, '1);
    issue(OP_QUERY, '0, -24'sd8388608, -24'sd8388608, -24'sd8388608, '0, '0);
    issue(OP_QUERY, '1, 24'sd8388607, 24'sd8388607, 24'sd8388607, '1, '1);
    issue(OP_QUERY, '0, 24'sd100, -24'sd100, 24'sd100, '0, '0);
    issue(OP_QUERY, '0, -24'sd5000, 24'sd0, 24'sd0, '0, '0);
    issue(2'd3, '1, '1, '1, '1, '1, '1);
    issue(OP_CLEAR, '0, '0, '0, '0, '0, '0);
    issue(OP_QUERY, '0, 24'sd5000, 24'sd0, 24'sd0, '0, '0);
    issue(OP_QUERY, '0, '0, '0, '0, '0, '0);
    // at radius max the root is not whole but both its children are
    set_radius('1);
    issue(OP_QUERY, '0, -24'sd8388608, 24'sd8388607, -24'sd8388608, '0, '0);

    // random phases: radius, tree shape, then a query-heavy mix
    for (int ph = 0; ph < 6; ph++) begin
      spread = 1 << $urandom_range(10, 20);
      base   = int'($urandom_range(0, 2 * (COORD_MAX - (1 << 21))))
               - (COORD_MAX - (1 << 21));
      case (ph)
        0: set_radius(RAD_W'(spread));
        1: set_radius(RAD_W'(spread / 2));
        2: set_radius(RAD_W'($urandom()));
        3: set_radius('0);
        4: set_radius('1);
        default: set_radius(RAD_W'($urandom_range(spread / 4, 2 * spread)));
      endcase
      // last phase runs with no gaps on either side
      if (ph == 5) quiet = 1'b1;
      build_tree((ph == 2) ? 4 : $urandom_range(2, 3), ph == 1 || ph == 4,
                 base, spread, ph == 2);
      // one long receiver hold while queries keep coming and back up the input
      if (ph == 1) hold_req = 1'b1;
      mixed_run(12, base, spread, ph == 2);
    end

    settle();
    repeat (200) @(posedge clk);
    $display("covered %0d node writes, %0d queries, %0d clears, %0d ignored items",
             n_writes, n_queries, n_clears, n_noise);
    $display("radius set from zero to max over full trees and a spine to the last level");
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/kdrc_pkg.sv
src/kdrc_in_if.sv
src/kdrc_out_if.sv
src/kdrc_front.sv
src/kdrc_isqrt.sv
src/kdrc_back.sv
src/kd_tree_radius_count_top.sv
sim/kdrc_checker.sv
sim/kd_tree_radius_count_top_tb.sv
